### sv/incremental_pid_speed_loop_defines.svh
`ifndef INCREMENTAL_PID_SPEED_LOOP_DEFINES_SVH
`define INCREMENTAL_PID_SPEED_LOOP_DEFINES_SVH

// Same-cycle implication check, disabled while reset is active
`define IPID_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication check, disabled while reset is active
`define IPID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### sv/ipid_pkg.sv
package ipid_pkg;

	localparam int GAIN_W          = 16;
	localparam int SPEED_W         = 16;
	localparam int ERR_W           = 17;
	localparam int DRIVE_W         = 32;
	// enough for accumulator plus the three full-precision products
	localparam int SUM_W           = 38;
	localparam int NUM_PROF        = 3;
	localparam int NUM_REGS        = 8;
	localparam int ADDR_W          = 5;
	localparam int DATA_W          = 32;
	localparam int DEF_DRIVE_LIMIT = 49000;

	// profile codes
	localparam logic [1:0] PROF_CRUISE = 2'd0;
	localparam logic [1:0] PROF_DETECT = 2'd1;
	localparam logic [1:0] PROF_HALT   = 2'd2;
	localparam logic [1:0] PROF_NONE   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_CRUISE_KP = 3'd0;
	localparam logic [2:0] REG_CRUISE_KI = 3'd1;
	localparam logic [2:0] REG_CRUISE_KD = 3'd2;
	localparam logic [2:0] REG_DETECT_KP = 3'd3;
	localparam logic [2:0] REG_DETECT_KI = 3'd4;
	localparam logic [2:0] REG_DETECT_KD = 3'd5;
	localparam logic [2:0] REG_HALT_KP   = 3'd6;
	localparam logic [2:0] REG_HALT_KD   = 3'd7;

	typedef struct packed {
		logic signed [GAIN_W-1:0] kp;
		logic signed [GAIN_W-1:0] ki;
		logic signed [GAIN_W-1:0] kd;
	} gain_set_t;

	typedef struct packed {
		gain_set_t                cruise;
		gain_set_t                detect;
		logic signed [GAIN_W-1:0] halt_kp;
		logic signed [GAIN_W-1:0] halt_kd;
	} gains_t;

endpackage

### sv/ipid_cfg_regs.sv
module ipid_cfg_regs
	import ipid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output gains_t            gains
);

	logic signed [GAIN_W-1:0] gain_q [NUM_REGS];
	logic [2:0]               idx;

	assign idx = paddr[ADDR_W-1:2];

	// gain writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) gain_q[i] <= '0;
		end else if (psel && penable && pwrite) begin
			gain_q[idx] <= pwdata[GAIN_W-1:0];
		end
	end

	// readback, sign-extended
	assign prdata = {{(DATA_W-GAIN_W){gain_q[idx][GAIN_W-1]}}, gain_q[idx]};

	assign gains.cruise.kp = gain_q[REG_CRUISE_KP];
	assign gains.cruise.ki = gain_q[REG_CRUISE_KI];
	assign gains.cruise.kd = gain_q[REG_CRUISE_KD];
	assign gains.detect.kp = gain_q[REG_DETECT_KP];
	assign gains.detect.ki = gain_q[REG_DETECT_KI];
	assign gains.detect.kd = gain_q[REG_DETECT_KD];
	assign gains.halt_kp   = gain_q[REG_HALT_KP];
	assign gains.halt_kd   = gain_q[REG_HALT_KD];

endmodule

### sv/ipid_core.sv
module ipid_core
	import ipid_pkg::*;
#(
	parameter int DRIVE_LIMIT = DEF_DRIVE_LIMIT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      upd,
	input  logic [1:0]                op,
	input  logic signed [SPEED_W-1:0] meas,
	input  logic signed [SPEED_W-1:0] targ,
	input  gains_t                    gains,
	output logic signed [DRIVE_W-1:0] drive_next
);

	localparam int D1_W = ERR_W + 1;
	localparam int D2_W = ERR_W + 2;

	localparam logic signed [SUM_W-1:0] LIM_HI = SUM_W'(DRIVE_LIMIT);
	localparam logic signed [SUM_W-1:0] LIM_LO = -LIM_HI;
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-DRIVE_W+1){1'b0}}, {(DRIVE_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

	// per-profile state
	logic signed [DRIVE_W-1:0] accum_q [NUM_PROF];
	logic signed [ERR_W-1:0]   e1_q    [NUM_PROF];
	logic signed [ERR_W-1:0]   e2_q    [NUM_PROF];

	logic [1:0]                     p;
	logic signed [GAIN_W-1:0]       kp, ki, kd;
	logic signed [ERR_W-1:0]        e, e1, e2;
	logic signed [DRIVE_W-1:0]      acc_cur;
	logic signed [D1_W-1:0]         d1;
	logic signed [D2_W-1:0]         d2;
	logic signed [GAIN_W+D1_W-1:0]  prod_p;
	logic signed [GAIN_W+ERR_W-1:0] prod_i;
	logic signed [GAIN_W+D2_W-1:0]  prod_d;
	logic signed [SUM_W-1:0]        sum;
	logic signed [SUM_W-1:0]        lo, hi, clamped;

	// unused profile code reads entry 0 but never writes
	assign p       = (op == PROF_NONE) ? PROF_CRUISE : op;
	assign e1      = e1_q[p];
	assign e2      = e2_q[p];
	assign acc_cur = accum_q[p];

	// gain select and error
	always_comb begin
		kp = '0;
		ki = '0;
		kd = '0;
		e  = '0;
		case (op)
			PROF_CRUISE: begin
				kp = gains.cruise.kp;
				ki = gains.cruise.ki;
				kd = gains.cruise.kd;
				e  = ERR_W'(targ) - ERR_W'(meas);
			end
			PROF_DETECT: begin
				kp = gains.detect.kp;
				ki = gains.detect.ki;
				kd = gains.detect.kd;
				e  = ERR_W'(targ) - ERR_W'(meas);
			end
			PROF_HALT: begin
				kp = gains.halt_kp;
				kd = gains.halt_kd;
				e  = -ERR_W'(meas);
			end
			default: begin
			end
		endcase
	end

	// velocity-form increment at full precision
	assign d1     = D1_W'(e) - D1_W'(e1);
	assign d2     = D2_W'(e) - (D2_W'(e1) <<< 1) + D2_W'(e2);
	assign prod_p = kp * d1;
	assign prod_i = ki * e;
	assign prod_d = kd * d2;
	assign sum    = SUM_W'(acc_cur) + SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

	// stop profile saturates at the word range, others at the drive limit
	always_comb begin
		lo = (op == PROF_HALT) ? SAT_LO : LIM_LO;
		hi = (op == PROF_HALT) ? SAT_HI : LIM_HI;
		if (sum < lo) clamped = lo;
		else if (sum > hi) clamped = hi;
		else clamped = sum;
	end

	assign drive_next = (op == PROF_NONE) ? '0 : DRIVE_W'(clamped);

	// state update as the transaction moves to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PROF; i++) begin
				accum_q[i] <= '0;
				e1_q[i]    <= '0;
				e2_q[i]    <= '0;
			end
		end else if (upd && op != PROF_NONE) begin
			accum_q[p] <= DRIVE_W'(clamped);
			e1_q[p]    <= e;
			e2_q[p]    <= e1;
		end
	end

endmodule

### sv/incremental_pid_speed_loop.sv
// An accepted input transaction is registered in the input stage and its drive result in
// the output register, on out_valid. Throughput: one transaction per cycle unless out_stall
// holds it; profile state is read, updated and written back between input and output registers.
// Reset: arst_n asynchronous, active low; clears gains, all profile accumulators and
// error histories, and both valid flags. No clearing pass is needed.
`include "incremental_pid_speed_loop_defines.svh"

module incremental_pid_speed_loop
	import ipid_pkg::*;
#(
	parameter int DRIVE_LIMIT = DEF_DRIVE_LIMIT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                operation,
	input  logic signed [SPEED_W-1:0] measured_speed,
	input  logic signed [SPEED_W-1:0] target_speed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [DRIVE_W-1:0] drive,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ADDR_W-1:0]         paddr,
	input  logic [DATA_W-1:0]         pwdata,
	output logic [DATA_W-1:0]         prdata,
	output logic                      pready
);

	localparam logic signed [DRIVE_W-1:0] LIM32 = DRIVE_W'(DRIVE_LIMIT);

	gains_t                    gains;
	logic                      valid_s1;
	logic [1:0]                op_s1;
	logic signed [SPEED_W-1:0] meas_s1;
	logic signed [SPEED_W-1:0] targ_s1;
	logic                      out_valid_q;
	logic signed [DRIVE_W-1:0] drive_q;
	logic signed [DRIVE_W-1:0] drive_next;
	logic                      adv;
	logic                      upd;

	assign pready = 1'b1;

	ipid_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.gains   (gains)
	);

	// handshake: stage 1 moves on whenever the output register is free or taken
	assign adv      = !out_valid_q || !out_stall;
	assign upd      = adv && valid_s1;
	assign in_stall = valid_s1 && !adv;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= operation;
			meas_s1 <= measured_speed;
			targ_s1 <= target_speed;
		end
	end

	ipid_core #(
		.DRIVE_LIMIT (DRIVE_LIMIT)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.op         (op_s1),
		.meas       (meas_s1),
		.targ       (targ_s1),
		.gains      (gains),
		.drive_next (drive_next)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) drive_q <= drive_next;
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	// checks
	`IPID_ASSERT_IMP(a_stall_only_on_backpressure, clk, arst_n, in_stall, out_valid && out_stall)
	`IPID_ASSERT_NEXT(a_clamped_profiles, clk, arst_n, upd && (op_s1 == PROF_CRUISE || op_s1 == PROF_DETECT), drive <= LIM32 && drive >= -LIM32)
	`IPID_ASSERT_NEXT(a_unused_profile_zero, clk, arst_n, upd && op_s1 == PROF_NONE, out_valid && drive == '0)

endmodule
